@@ design/rgb_hsv_color_converter_macros.svh @@
// ---------------------------------------------------------------------------
// rgb_hsv_color_converter assertion macros
// concurrent check helpers, empty when synthesising
// ---------------------------------------------------------------------------
`ifndef RGB_HSV_COLOR_CONVERTER_MACROS_SVH
`define RGB_HSV_COLOR_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define RHC_ASSERT(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("rhc assertion failed");
// condition must never be true outside reset
`define RHC_ASSERT_NEVER(lbl, ck, rst_n, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) !(cond)) \
		else $error("rhc forbidden condition seen");
`else
`define RHC_ASSERT(lbl, ck, rst_n, prop)
`define RHC_ASSERT_NEVER(lbl, ck, rst_n, cond)
`endif

`endif

@@ design/rhc_pkg.sv @@
// ---------------------------------------------------------------------------
// rhc_pkg
// constants and the channel rounding function of the colour converter
// ---------------------------------------------------------------------------
`default_nettype none
package rhc_pkg;

	// hue units per sector (60 degrees in 1/64 degree)
	localparam logic [14:0] SECTOR_UNITS = 15'd3840;
	localparam logic [14:0] FULL_TURN    = 15'd23040;
	localparam logic [15:0] Q15_ONE      = 16'd32768;
	// 32768 * 3840, the factor of one
	localparam logic [26:0] F_ONE        = 27'd125829120;
	// half of 2^38 * 15, the rounding offset
	localparam logic [50:0] HALF_DEN     = 51'd15 << 37;
	// ceil(2^16 / 15)
	localparam logic [12:0] RCP15        = 13'd4370;
	// ceil(2^31 / 255)
	localparam logic [31:0] RCP255       = 32'((64'd2147483648 + 64'd254) / 64'd255);

	// v * f (43 bits) times 255, rounded half up over 2^38 * 15, clamped
	function automatic logic [7:0] chan(input logic [42:0] p);
		logic [50:0] x;
		logic [12:0] y;
		logic [25:0] z;
		logic [9:0]  r;
		x = ({p, 8'd0} - {8'd0, p}) + HALF_DEN;
		y = x[50:38];
		z = y * RCP15;
		r = z[25:16];
		chan = (r > 10'd255) ? 8'd255 : r[7:0];
	endfunction

endpackage
`default_nettype wire

@@ design/rgb_hsv_color_converter.sv @@
// ---------------------------------------------------------------------------
// rgb_hsv_color_converter
// per-pixel converter between 8-bit rgb and hsv in 1/64 degree and Q1.15
// ---------------------------------------------------------------------------
// usage
//   source channel: src_valid / src_stall carry one pixel word with mode,
//   rgb fields (mode 0) and hsv fields (mode 1)
//   result channel: dst_valid / dst_stall carry one result word per pixel;
//   the fields of the unused direction are zero
//   pipeline: dst_valid is the last of four valid registers, the first
//   loaded at the accepting edge
//   throughput: one pixel per cycle while not stalled, set by the four-stage
//   datapath in which each stage holds at most one multiplier level
//   stall: when dst_stall holds a waiting result, the whole pipeline freezes
//   and src_stall is raised in the same cycle; nothing is lost or repeated
//   reset: arst_n clears all valid bits at once; no clearing pass is needed
// ---------------------------------------------------------------------------
`default_nettype none
`include "rgb_hsv_color_converter_macros.svh"
module rgb_hsv_color_converter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire logic        mode,
	input  wire logic [7:0]  red_in,
	input  wire logic [7:0]  green_in,
	input  wire logic [7:0]  blue_in,
	input  wire logic [14:0] hue_in,
	input  wire logic [15:0] sat_in,
	input  wire logic [15:0] val_in,
	output logic             dst_valid,
	input  wire logic        dst_stall,
	output logic      [14:0] hue_out,
	output logic      [15:0] sat_out,
	output logic      [15:0] val_out,
	output logic      [7:0]  red_out,
	output logic      [7:0]  green_out,
	output logic      [7:0]  blue_out
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	logic mode_s1, mode_s2, mode_s3, mode_s4;

	// pipeline advance unless a finished word is held
	assign en        = !(v_s4 && dst_stall);
	assign src_stall = !en;
	assign dst_valid = v_s4;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= src_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// mode alongside, for checking
	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			mode_s2 <= mode_s1;
			mode_s3 <= mode_s2;
			mode_s4 <= mode_s3;
		end
	end

	// rgb to hsv path
	rhc_fwd u_fwd (
		.clk      (clk),
		.en       (en),
		.mode     (mode),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.hue_out  (hue_out),
		.sat_out  (sat_out),
		.val_out  (val_out)
	);

	// hsv to rgb path
	rhc_inv u_inv (
		.clk       (clk),
		.en        (en),
		.mode      (mode),
		.hue_in    (hue_in),
		.sat_in    (sat_in),
		.val_in    (val_in),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

	// checks
	`RHC_ASSERT(a_accept_enters, clk, arst_n, src_valid && !src_stall |=> v_s1)
	`RHC_ASSERT_NEVER(a_hue_range, clk, arst_n, dst_valid && hue_out >= 15'd23040)
	`RHC_ASSERT_NEVER(a_rgb_unused, clk, arst_n, dst_valid && !mode_s4 && (red_out != 8'd0 || green_out != 8'd0 || blue_out != 8'd0))
	`RHC_ASSERT_NEVER(a_hsv_unused, clk, arst_n, dst_valid && mode_s4 && (hue_out != 15'd0 || sat_out != 16'd0 || val_out != 16'd0))

endmodule
`default_nettype wire

@@ design/rhc_fwd.sv @@
// ---------------------------------------------------------------------------
// rhc_fwd
// rgb to hsv datapath, four register stages with reciprocal division
// ---------------------------------------------------------------------------
`default_nettype none
module rhc_fwd (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic        mode,
	input  wire logic [7:0]  red_in,
	input  wire logic [7:0]  green_in,
	input  wire logic [7:0]  blue_in,
	output logic      [14:0] hue_out,
	output logic      [15:0] sat_out,
	output logic      [15:0] val_out
);

	// reciprocal table ceil(2^31 / n), entry 0 unused
	logic [31:0] rcp_tab [256];
	for (genvar gi = 0; gi < 256; gi++) begin : g_rcp
		localparam int unsigned DV = (gi == 0) ? 1 : gi;
		localparam logic [31:0] RCP = (gi == 0) ? 32'd0 :
			32'((64'd2147483648 + 64'(DV) - 64'd1) / 64'(DV));
		assign rcp_tab[gi] = RCP;
	end

	// stage 1: max, min, delta and hue numerator in sector units
	logic [7:0]  mx, mn, d;
	logic [10:0] u;
	always_comb begin
		mx = red_in;
		mn = red_in;
		if (green_in > mx) mx = green_in;
		if (blue_in > mx) mx = blue_in;
		if (green_in < mn) mn = green_in;
		if (blue_in < mn) mn = blue_in;
		d = mx - mn;
		if (red_in == mx) begin
			if (green_in >= blue_in) u = 11'(green_in - blue_in);
			else u = 11'(6 * d) - 11'(blue_in - green_in);
		end else if (green_in == mx) begin
			u = 11'(2 * d) + 11'(blue_in) - 11'(red_in);
		end else begin
			u = 11'(4 * d) + 11'(red_in) - 11'(green_in);
		end
	end

	logic [7:0]  mx_s1, d_s1;
	logic [10:0] u_s1;
	logic        act_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1  <= mx;
			d_s1   <= d;
			u_s1   <= u;
			act_s1 <= !mode;
		end
	end

	// stage 2: numerators and reciprocals
	logic [22:0] nh_s2, ns_s2, nv_s2;
	logic [31:0] rd_s2, rm_s2;
	logic        grey_s2, act_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			nh_s2   <= 23'(u_s1 * 12'd3840);
			ns_s2   <= {d_s1, 15'd0};
			nv_s2   <= {mx_s1, 15'd0};
			rd_s2   <= rcp_tab[d_s1];
			rm_s2   <= rcp_tab[mx_s1];
			grey_s2 <= (d_s1 == 8'd0);
			act_s2  <= act_s1;
		end
	end

	// stage 3: reciprocal products
	logic [54:0] ph, ps, pv;
	assign ph = nh_s2 * rd_s2;
	assign ps = ns_s2 * rm_s2;
	assign pv = nv_s2 * rhc_pkg::RCP255;

	logic [14:0] h_s3;
	logic [15:0] s_s3, v_s3;
	logic        grey_s3, act_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			h_s3    <= ph[45:31];
			s_s3    <= ps[46:31];
			v_s3    <= pv[46:31];
			grey_s3 <= grey_s2;
			act_s3  <= act_s2;
		end
	end

	// stage 4: grey and mode masking
	always_ff @(posedge clk) begin
		if (en) begin
			hue_out <= (act_s3 && !grey_s3) ? h_s3 : 15'd0;
			sat_out <= (act_s3 && !grey_s3) ? s_s3 : 16'd0;
			val_out <= act_s3 ? v_s3 : 16'd0;
		end
	end

endmodule
`default_nettype wire

@@ design/rhc_inv.sv @@
// ---------------------------------------------------------------------------
// rhc_inv
// hsv to rgb datapath, four register stages of the p/q/t construction
// ---------------------------------------------------------------------------
`default_nettype none
module rhc_inv (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic        mode,
	input  wire logic [14:0] hue_in,
	input  wire logic [15:0] sat_in,
	input  wire logic [15:0] val_in,
	output logic      [7:0]  red_out,
	output logic      [7:0]  green_out,
	output logic      [7:0]  blue_out
);

	// stage 1: wrap hue, clamp inputs, split into sector and fraction
	logic [14:0] h, base;
	logic [2:0]  sec;
	always_comb begin
		h = (hue_in >= rhc_pkg::FULL_TURN) ? hue_in - rhc_pkg::FULL_TURN : hue_in;
		if (h >= 15'd19200) begin
			sec = 3'd5; base = 15'd19200;
		end else if (h >= 15'd15360) begin
			sec = 3'd4; base = 15'd15360;
		end else if (h >= 15'd11520) begin
			sec = 3'd3; base = 15'd11520;
		end else if (h >= 15'd7680) begin
			sec = 3'd2; base = 15'd7680;
		end else if (h >= rhc_pkg::SECTOR_UNITS) begin
			sec = 3'd1; base = rhc_pkg::SECTOR_UNITS;
		end else begin
			sec = 3'd0; base = 15'd0;
		end
	end

	logic [2:0]  sec_s1;
	logic [11:0] frac_s1;
	logic [15:0] s_s1, v_s1;
	logic        act_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			sec_s1  <= sec;
			frac_s1 <= 12'(h - base);
			s_s1    <= (sat_in > rhc_pkg::Q15_ONE) ? rhc_pkg::Q15_ONE : sat_in;
			v_s1    <= (val_in > rhc_pkg::Q15_ONE) ? rhc_pkg::Q15_ONE : val_in;
			act_s1  <= mode;
		end
	end

	// stage 2: factors of one minus s times fraction
	logic [27:0] sq, st, sp;
	assign sq = s_s1 * frac_s1;
	assign st = s_s1 * (12'd3840 - frac_s1);
	assign sp = s_s1 * 12'd3840;

	logic [26:0] fq_s2, ft_s2, fp_s2;
	logic [15:0] v_s2;
	logic [2:0]  sec_s2;
	logic        act_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			fq_s2  <= rhc_pkg::F_ONE - sq[26:0];
			ft_s2  <= rhc_pkg::F_ONE - st[26:0];
			fp_s2  <= rhc_pkg::F_ONE - sp[26:0];
			v_s2   <= v_s1;
			sec_s2 <= sec_s1;
			act_s2 <= act_s1;
		end
	end

	// stage 3: scale by value
	logic [42:0] pv_s3, pp_s3, pq_s3, pt_s3;
	logic [2:0]  sec_s3;
	logic        act_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			pv_s3  <= v_s2 * rhc_pkg::F_ONE;
			pp_s3  <= v_s2 * fp_s2;
			pq_s3  <= v_s2 * fq_s2;
			pt_s3  <= v_s2 * ft_s2;
			sec_s3 <= sec_s2;
			act_s3 <= act_s2;
		end
	end

	// stage 4: round each channel and route by sector
	logic [7:0] cv, cp, cq, ct, r, g, b;
	always_comb begin
		cv = rhc_pkg::chan(pv_s3);
		cp = rhc_pkg::chan(pp_s3);
		cq = rhc_pkg::chan(pq_s3);
		ct = rhc_pkg::chan(pt_s3);
		case (sec_s3)
			3'd0:    begin r = cv; g = ct; b = cp; end
			3'd1:    begin r = cq; g = cv; b = cp; end
			3'd2:    begin r = cp; g = cv; b = ct; end
			3'd3:    begin r = cp; g = cq; b = cv; end
			3'd4:    begin r = ct; g = cp; b = cv; end
			default: begin r = cv; g = cp; b = cq; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_out   <= act_s3 ? r : 8'd0;
			green_out <= act_s3 ? g : 8'd0;
			blue_out  <= act_s3 ? b : 8'd0;
		end
	end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// pixel-stream test of the rgb/hsv colour converter: directed corner pixels,
// then random pixels in both directions, with random gaps and result stalls;
// every result word is checked against an integer model of the conversion
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;

	typedef struct packed {
		logic [14:0] hue;
		logic [15:0] sat;
		logic [15:0] val;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} pixel_res_t;

	logic        clk;
	logic        arst_n;
	logic        src_valid;
	logic        src_stall;
	logic        mode;
	logic [7:0]  red_in;
	logic [7:0]  green_in;
	logic [7:0]  blue_in;
	logic [14:0] hue_in;
	logic [15:0] sat_in;
	logic [15:0] val_in;
	logic        dst_valid;
	logic        dst_stall;
	logic [14:0] hue_out;
	logic [15:0] sat_out;
	logic [15:0] val_out;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;

	pixel_res_t  pending_px[$];
	int          n_errors;
	int          n_checked;
	int          n_rgb;
	int          n_hsv;
	bit          idle_on;

	rgb_hsv_color_converter uut (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_stall(src_stall),
		.mode(mode), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.hue_in(hue_in), .sat_in(sat_in), .val_in(val_in),
		.dst_valid(dst_valid), .dst_stall(dst_stall),
		.hue_out(hue_out), .sat_out(sat_out), .val_out(val_out),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one channel value: v * (1 - s*m/3840) * 255, rounded half up, clamped
	function automatic logic [7:0] scale_chan(longint unsigned v, longint unsigned m,
			longint unsigned s);
		longint unsigned f, den, num, r;
		f = 64'd32768 * 64'd3840 - s * m;
		den = 64'd32768 * 64'd32768 * 64'd3840;
		num = v * f * 64'd255;
		r = (num + den / 2) / den;
		return (r > 255) ? 8'd255 : r[7:0];
	endfunction

	// expected result word for one pixel
	function automatic pixel_res_t convert_px(logic md, logic [7:0] r8, logic [7:0] g8,
			logic [7:0] b8, logic [14:0] h15, logic [15:0] s16, logic [15:0] v16);
		pixel_res_t res;
		longint unsigned r, g, b, mx, mn, d, num, h, s, v, frac;
		logic [7:0] cv, cp, cq, ct;
		res = '0;
		if (md == 1'b0) begin
			r = r8; g = g8; b = b8;
			mx = r; mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			d = mx - mn;
			res.val = 16'((mx * 32768) / 255);
			if (d != 0) begin
				res.sat = 16'((d * 32768) / mx);
				if (r == mx)
					num = (g >= b) ? 3840 * (g - b) : 23040 * d - 3840 * (b - g);
				else if (g == mx)
					num = 7680 * d + 3840 * b - 3840 * r;
				else
					num = 15360 * d + 3840 * r - 3840 * g;
				res.hue = 15'(num / d);
			end
		end else begin
			h = h15; s = s16; v = v16;
			if (h >= 23040) h -= 23040;
			if (s > 32768) s = 32768;
			if (v > 32768) v = 32768;
			cv = scale_chan(v, 0, 0);
			if (s == 0) begin
				res.red = cv[7:0]; res.green = cv[7:0]; res.blue = cv[7:0];
			end else begin
				frac = h % 3840;
				cp = scale_chan(v, 3840, s);
				cq = scale_chan(v, frac, s);
				ct = scale_chan(v, 3840 - frac, s);
				case (h / 3840)
					0: begin res.red = cv; res.green = ct; res.blue = cp; end
					1: begin res.red = cq; res.green = cv; res.blue = cp; end
					2: begin res.red = cp; res.green = cv; res.blue = ct; end
					3: begin res.red = cp; res.green = cq; res.blue = cv; end
					4: begin res.red = ct; res.green = cp; res.blue = cv; end
					default: begin res.red = cv; res.green = cp; res.blue = cq; end
				endcase
			end
		end
		return res;
	endfunction

	// random gap before a word
	task automatic source_gap();
		int n;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 18);
			src_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// send one pixel word and wait for acceptance
	task automatic send_px(logic md, logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [14:0] h, logic [15:0] s, logic [15:0] v);
		source_gap();
		src_valid <= 1'b1;
		mode <= md; red_in <= r; green_in <= g; blue_in <= b;
		hue_in <= h; sat_in <= s; val_in <= v;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		pending_px.push_back(convert_px(md, r, g, b, h, s, v));
		if (md) n_hsv++; else n_rgb++;
	endtask

	task automatic send_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		send_px(1'b0, r, g, b, 15'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic send_hsv(logic [14:0] h, logic [15:0] s, logic [15:0] v);
		send_px(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), h, s, v);
	endtask

	// hold off the source until the pipeline has drained
	task automatic wait_drained();
		src_valid <= 1'b0;
		@(posedge clk);
		while (pending_px.size() != 0) @(posedge clk);
	endtask

	// corner pixels for rgb to hsv: black, white, greys, each hue sector
	task automatic test_rgb_corners();
		send_rgb(8'd0, 8'd0, 8'd0);
		send_rgb(8'd255, 8'd255, 8'd255);
		send_rgb(8'd128, 8'd128, 8'd128);
		send_rgb(8'd255, 8'd0, 8'd0);
		send_rgb(8'd0, 8'd255, 8'd0);
		send_rgb(8'd0, 8'd0, 8'd255);
		send_rgb(8'd255, 8'd0, 8'd1);
		send_rgb(8'd255, 8'd255, 8'd0);
		send_rgb(8'd0, 8'd255, 8'd255);
		send_rgb(8'd1, 8'd0, 8'd0);
		send_rgb(8'd200, 8'd200, 8'd100);
		send_rgb(8'd10, 8'd30, 8'd30);
	endtask

	// corner pixels for hsv to rgb: zero saturation, wrap, over-range s and v
	task automatic test_hsv_corners();
		send_hsv(15'd0, 16'd0, 16'd32768);
		send_hsv(15'd0, 16'd0, 16'd0);
		send_hsv(15'd0, 16'd32768, 16'd32768);
		send_hsv(15'd3839, 16'd32768, 16'd32768);
		send_hsv(15'd23039, 16'd32768, 16'd32768);
		send_hsv(15'd23040, 16'd20000, 16'd30000);
		send_hsv(15'h7fff, 16'hffff, 16'hffff);
		send_hsv(15'd7680, 16'd40000, 16'd16384);
		send_hsv(15'd11520, 16'd1, 16'd1);
		send_hsv(15'd15360, 16'd16384, 16'd32767);
		send_hsv(15'd19200, 16'd32768, 16'd65535);
		send_hsv(15'd13000, 16'd0, 16'd12345);
	endtask

	// random pixels, mostly in range, some with out-of-range hsv fields
	task automatic test_random_pixels(int count);
		logic [14:0] h;
		logic [15:0] s, v;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 1)) begin
				if ($urandom_range(0, 7) == 0)
					send_rgb(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				else begin
					v = 16'($urandom);
					send_rgb(v[7:0], v[7:0] ^ 8'($urandom_range(0, 3)), 8'($urandom));
				end
			end else begin
				if ($urandom_range(0, 5) == 0) begin
					h = 15'($urandom); s = 16'($urandom); v = 16'($urandom);
				end else begin
					h = 15'($urandom_range(0, 23039));
					s = 16'($urandom_range(0, 32768));
					v = 16'($urandom_range(0, 32768));
				end
				send_hsv(h, s, v);
			end
			if (i == count / 2) wait_drained();
		end
	endtask

	// result stalls in random bursts
	initial begin
		dst_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				dst_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			dst_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		pixel_res_t exp_px;
		if (arst_n && dst_valid && !dst_stall) begin
			if (pending_px.size() == 0) begin
				$error("result word with nothing expected");
				n_errors++;
			end else begin
				exp_px = pending_px.pop_front();
				n_checked++;
				if (hue_out !== exp_px.hue) begin
					$error("hue_out exp %0d got %0d", exp_px.hue, hue_out); n_errors++;
				end
				if (sat_out !== exp_px.sat) begin
					$error("sat_out exp %0d got %0d", exp_px.sat, sat_out); n_errors++;
				end
				if (val_out !== exp_px.val) begin
					$error("val_out exp %0d got %0d", exp_px.val, val_out); n_errors++;
				end
				if (red_out !== exp_px.red) begin
					$error("red_out exp %0d got %0d", exp_px.red, red_out); n_errors++;
				end
				if (green_out !== exp_px.green) begin
					$error("green_out exp %0d got %0d", exp_px.green, green_out); n_errors++;
				end
				if (blue_out !== exp_px.blue) begin
					$error("blue_out exp %0d got %0d", exp_px.blue, blue_out); n_errors++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	// main sequence
	initial begin
		int guard;
		n_errors = 0; n_checked = 0; n_rgb = 0; n_hsv = 0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		src_valid = 1'b0;
		mode = 1'b0; red_in = '0; green_in = '0; blue_in = '0;
		hue_in = '0; sat_in = '0; val_in = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_rgb_corners();
		test_hsv_corners();
		test_random_pixels(320);
		idle_on = 1'b0;
		test_random_pixels(60);
		src_valid <= 1'b0;
		guard = 0;
		while (pending_px.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (pending_px.size() != 0) begin
			$error("%0d result words never arrived", pending_px.size());
			n_errors++;
		end
		$display("converted %0d rgb and %0d hsv pixels, %0d result words checked",
			n_rgb, n_hsv, n_checked);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
